// ===== rtl/throttle_ramp_limiter_failsafe_macros.svh =====
// assertion macros shared by the throttle ramp limiter rtl
`ifndef THROTTLE_RAMP_LIMITER_FAILSAFE_MACROS_SVH
`define THROTTLE_RAMP_LIMITER_FAILSAFE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TRL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trl assertion failed");
// next-cycle implication
`define TRL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trl assertion failed");
`else
`define TRL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TRL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/trl_pkg.sv =====
// shared types and constants of the throttle ramp limiter
`default_nettype none
package trl_pkg;

  localparam int unsigned FULL_SCALE_DEF = 10000;
  localparam int unsigned TIME_WIDTH_DEF = 20;

  localparam int unsigned CMD_W     = 15;
  localparam int unsigned LEVEL_W   = 15;
  localparam int unsigned MAG_W     = 15;
  localparam int unsigned FS_W      = 15;
  localparam int unsigned DZ_W      = 13;
  localparam int unsigned RATE_W    = 20;
  localparam int unsigned ELAPSED_W = 20;
  localparam int unsigned US_W      = 20;
  localparam int unsigned US_PER_S  = 1000000;
  localparam int unsigned DIV_W     = 40;
  localparam int unsigned DIVISOR_W = 20;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;

  localparam logic [DZ_W-1:0]   DEADZONE_RST = DZ_W'(1000);
  localparam logic [RATE_W-1:0] ACCEL_RST    = RATE_W'(7500);
  localparam logic [RATE_W-1:0] DECEL_RST    = RATE_W'(50000);
  localparam logic [RATE_W-1:0] COAST_RST    = RATE_W'(20000);

  typedef enum logic [1:0] {
    REG_DEADZONE,
    REG_ACCEL,
    REG_DECEL,
    REG_COAST
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TARGET,
    ST_TGT_WAIT,
    ST_STRETCH,
    ST_DECIDE,
    ST_XWAIT,
    ST_DWAIT,
    ST_FINISH
  } trl_state_e;

  typedef enum logic [1:0] {
    DIV_TARGET,
    DIV_CROSS,
    DIV_STEP
  } div_op_e;

  typedef struct packed {
    logic [DZ_W-1:0]   deadzone;
    logic [RATE_W-1:0] accel_rate;
    logic [RATE_W-1:0] decel_rate;
    logic [RATE_W-1:0] coast_rate;
  } trl_cfg_t;

  typedef struct packed {
    logic    load;
    logic    tgt_init;
    logic    tgt_apply;
    logic    stretch;
    logic    div_start;
    div_op_e div_op;
    logic    cross_apply;
    logic    step_apply;
    logic    out_load;
  } trl_cmd_t;

  typedef struct packed {
    logic tgt_need_div;
    logic settled;
    logic cross_take;
    logic div_done;
    logic arm;
  } trl_status_t;

endpackage
`default_nettype wire

// ===== rtl/trl_regs.sv =====
// apb register file holding deadzone and ramp rates
`default_nettype none
module trl_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trl_pkg::ADDR_W-1:0]    paddr,
  input  logic [trl_pkg::DATA_W-1:0]    pwdata,
  output logic [trl_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output trl_pkg::trl_cfg_t             cfg_o
);
  import trl_pkg::*;

  trl_cfg_t cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_DEADZONE: cfg_d.deadzone   = pwdata[DZ_W-1:0];
        REG_ACCEL:    cfg_d.accel_rate = pwdata[RATE_W-1:0];
        REG_DECEL:    cfg_d.decel_rate = pwdata[RATE_W-1:0];
        REG_COAST:    cfg_d.coast_rate = pwdata[RATE_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEADZONE: prdata = DATA_W'(cfg_q.deadzone);
      REG_ACCEL:    prdata = DATA_W'(cfg_q.accel_rate);
      REG_DECEL:    prdata = DATA_W'(cfg_q.decel_rate);
      REG_COAST:    prdata = DATA_W'(cfg_q.coast_rate);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadzone   <= DEADZONE_RST;
      cfg_q.accel_rate <= ACCEL_RST;
      cfg_q.decel_rate <= DECEL_RST;
      cfg_q.coast_rate <= COAST_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/trl_div.sv =====
// iterative restoring divider, two quotient bits per cycle
`default_nettype none
module trl_div #(
  parameter int unsigned DIVIDEND_W = trl_pkg::DIV_W,
  parameter int unsigned DIVISOR_W  = trl_pkg::DIVISOR_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);
  localparam int unsigned ITER  = (DIVIDEND_W + 1) / 2;
  localparam int unsigned PAD_W = 2 * ITER;
  localparam int unsigned CNT_W = $clog2(ITER + 1);

  logic [DIVISOR_W:0]   rem_q, rem_d;
  logic [PAD_W-1:0]     quo_q, quo_d;
  logic [DIVISOR_W-1:0] dsr_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 done_q;

  // two shift-subtract steps
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    for (int k = 0; k < 2; k++) begin
      rem_d = {rem_d[DIVISOR_W-1:0], quo_d[PAD_W-1]};
      quo_d = {quo_d[PAD_W-2:0], 1'b0};
      if (rem_d >= {1'b0, dsr_q}) begin
        rem_d    = rem_d - {1'b0, dsr_q};
        quo_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(ITER);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= PAD_W'(dividend_i);
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[DIVIDEND_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/trl_dp.sv =====
// datapath: arm flag, target, ramped level and output register
`default_nettype none
module trl_dp #(
  parameter int unsigned FULL_SCALE = trl_pkg::FULL_SCALE_DEF,
  parameter int unsigned TIME_WIDTH = trl_pkg::TIME_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  trl_pkg::trl_cfg_t                    cfg_i,
  input  trl_pkg::trl_cmd_t                    cmd_i,
  input  logic signed [trl_pkg::CMD_W-1:0]     command_level_i,
  input  logic [trl_pkg::ELAPSED_W-1:0]        elapsed_us_i,
  input  logic                                 link_lost_i,
  input  logic                                 setup_mode_i,
  output trl_pkg::trl_status_t                 status_o,
  output logic signed [trl_pkg::LEVEL_W-1:0]   ramped_level_o,
  output logic signed [trl_pkg::LEVEL_W-1:0]   target_level_o,
  output logic                                 armed_o
);
  import trl_pkg::*;

  localparam int unsigned TW = (TIME_WIDTH < ELAPSED_W) ? TIME_WIDTH : ELAPSED_W;
  localparam int unsigned LevelMax = (FULL_SCALE < 16383) ? FULL_SCALE : 16383;
  localparam logic signed [LEVEL_W-1:0] LvlPos = LEVEL_W'(LevelMax);
  localparam logic signed [LEVEL_W-1:0] LvlNeg = -LvlPos;
  localparam logic [FS_W-1:0] FsVal = FS_W'(FULL_SCALE);

  // per-item registers
  logic                        neg_q;
  logic [MAG_W-1:0]            mag_q;
  logic [TW-1:0]               time_q;
  logic                        failsafe_q;
  logic signed [LEVEL_W-1:0]   target_q;
  logic [RATE_W-1:0]           rate_q;
  logic [DIV_W-1:0]            prod_q;
  logic [DIV_W-1:0]            distp_q;
  logic                        up_q;
  logic                        cross_q;
  // kept state
  logic signed [LEVEL_W-1:0]   level_q, level_d;
  logic                        arm_q, arm_d;
  // output register
  logic signed [LEVEL_W-1:0]   ramped_q;
  logic signed [LEVEL_W-1:0]   tout_q;
  logic                        armed_q;

  logic [MAG_W-1:0]            in_mag;
  logic [MAG_W-1:0]            dz_m;
  logic                        beyond_dz;
  logic                        dz_below_fs;
  logic signed [LEVEL_W-1:0]   tgt_direct;
  logic [LEVEL_W-1:0]          tgt_mag;
  logic signed [LEVEL_W-1:0]   tgt_div;
  logic [DIV_W-1:0]            tgt_num;
  logic [DIVISOR_W-1:0]        tgt_den;

  logic                        lvl_lt, lvl_gt, lvl_neg, lvl_pos, tgt_neg, tgt_pos;
  logic                        accel;
  logic [RATE_W-1:0]           rate_sel;
  logic                        cross_side;
  logic [MAG_W-1:0]            abs_lvl;
  logic [RATE_W+TW-1:0]        prod_n;
  logic [MAG_W+US_W-1:0]       distp_n;
  logic [LEVEL_W:0]            gap;
  logic                        step_reach;
  logic [LEVEL_W-1:0]          lvl_step;

  logic                        div_start;
  logic [DIV_W-1:0]            div_num;
  logic [DIVISOR_W-1:0]        div_den;
  logic                        div_done;
  logic [DIV_W-1:0]            div_quo;

  // arming and input magnitude
  assign in_mag = command_level_i[CMD_W-1] ? (MAG_W'(~command_level_i) + MAG_W'(1))
                                           : MAG_W'(command_level_i);
  assign dz_m   = MAG_W'(cfg_i.deadzone);
  assign arm_d  = link_lost_i ? 1'b0 : ((in_mag <= dz_m) ? 1'b1 : arm_q);

  // target
  assign beyond_dz   = mag_q > dz_m;
  assign dz_below_fs = FS_W'(cfg_i.deadzone) < FsVal;
  assign tgt_direct  = (failsafe_q || !beyond_dz) ? '0 : (neg_q ? LvlNeg : LvlPos);
  assign tgt_num     = DIV_W'(mag_q - dz_m) * DIV_W'(FsVal);
  assign tgt_den     = DIVISOR_W'(FsVal - FS_W'(cfg_i.deadzone));
  assign tgt_mag     = (div_quo > DIV_W'(LevelMax)) ? LEVEL_W'(LevelMax)
                                                    : div_quo[LEVEL_W-1:0];
  assign tgt_div     = neg_q ? -$signed(tgt_mag) : $signed(tgt_mag);

  // stretch setup
  assign lvl_lt  = level_q < target_q;
  assign lvl_gt  = level_q > target_q;
  assign lvl_neg = level_q[LEVEL_W-1];
  assign lvl_pos = !lvl_neg && (level_q != '0);
  assign tgt_neg = target_q[LEVEL_W-1];
  assign tgt_pos = !tgt_neg && (target_q != '0);
  assign accel   = (tgt_pos && lvl_lt && !lvl_neg) || (tgt_neg && lvl_gt && !lvl_pos);
  assign rate_sel = failsafe_q ? cfg_i.coast_rate
                  : (accel ? cfg_i.accel_rate : cfg_i.decel_rate);
  assign cross_side = (lvl_lt && lvl_neg && !tgt_neg) || (lvl_gt && lvl_pos && !tgt_pos);
  assign abs_lvl = lvl_neg ? (MAG_W'(~level_q) + MAG_W'(1)) : MAG_W'(level_q);
  assign prod_n  = rate_sel * time_q;
  assign distp_n = abs_lvl * US_W'(US_PER_S);

  // final move of a stretch, clamped at the target
  assign gap = up_q ? ({target_q[LEVEL_W-1], target_q} - {level_q[LEVEL_W-1], level_q})
                    : ({level_q[LEVEL_W-1], level_q} - {target_q[LEVEL_W-1], target_q});
  assign step_reach = div_quo >= DIV_W'(gap);
  assign lvl_step   = up_q ? (LEVEL_W'(level_q) + div_quo[LEVEL_W-1:0])
                           : (LEVEL_W'(level_q) - div_quo[LEVEL_W-1:0]);

  always_comb begin
    level_d = level_q;
    if (cmd_i.cross_apply) begin
      level_d = '0;
    end else if (cmd_i.step_apply) begin
      level_d = step_reach ? target_q : $signed(lvl_step);
    end
  end

  // divider operand select
  assign div_start = cmd_i.div_start;
  always_comb begin
    unique case (cmd_i.div_op)
      DIV_TARGET: begin
        div_num = tgt_num;
        div_den = tgt_den;
      end
      DIV_CROSS: begin
        div_num = distp_q + DIV_W'(rate_q) - DIV_W'(1);
        div_den = DIVISOR_W'(rate_q);
      end
      DIV_STEP: begin
        div_num = prod_q;
        div_den = DIVISOR_W'(US_PER_S);
      end
      default: begin
        div_num = prod_q;
        div_den = DIVISOR_W'(US_PER_S);
      end
    endcase
  end

  trl_div #(
    .DIVIDEND_W(DIV_W),
    .DIVISOR_W (DIVISOR_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_den),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      arm_q   <= 1'b0;
    end else begin
      level_q <= level_d;
      if (cmd_i.load) begin
        arm_q <= arm_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q      <= command_level_i[CMD_W-1];
      mag_q      <= in_mag;
      time_q     <= elapsed_us_i[TW-1:0];
      failsafe_q <= link_lost_i || setup_mode_i || !arm_d;
    end else if (cmd_i.cross_apply) begin
      time_q <= time_q - div_quo[TW-1:0];
    end
    if (cmd_i.tgt_init) begin
      target_q <= tgt_direct;
    end else if (cmd_i.tgt_apply) begin
      target_q <= tgt_div;
    end
    if (cmd_i.stretch) begin
      rate_q  <= rate_sel;
      prod_q  <= DIV_W'(prod_n);
      distp_q <= DIV_W'(distp_n);
      up_q    <= lvl_lt;
      cross_q <= cross_side;
    end
    if (cmd_i.out_load) begin
      ramped_q <= level_q;
      tout_q   <= target_q;
      armed_q  <= arm_q;
    end
  end

  assign status_o.tgt_need_div = !failsafe_q && beyond_dz && dz_below_fs;
  assign status_o.settled      = (time_q == '0) || (level_q == target_q);
  assign status_o.cross_take   = cross_q && (prod_q > distp_q);
  assign status_o.div_done     = div_done;
  assign status_o.arm          = arm_q;

  assign ramped_level_o = ramped_q;
  assign target_level_o = tout_q;
  assign armed_o        = armed_q;

endmodule
`default_nettype wire

// ===== rtl/trl_ctrl.sv =====
// controller state machine sequencing one update
`default_nettype none
module trl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  trl_pkg::trl_status_t  status_i,
  output trl_pkg::trl_cmd_t     cmd_o
);
  import trl_pkg::*;

  trl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.div_op = DIV_STEP;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_TARGET;
        end
      end
      ST_TARGET: begin
        cmd_o.tgt_init = 1'b1;
        if (status_i.tgt_need_div) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = DIV_TARGET;
          state_d         = ST_TGT_WAIT;
        end else begin
          state_d = ST_STRETCH;
        end
      end
      ST_TGT_WAIT: begin
        cmd_o.div_op = DIV_TARGET;
        if (status_i.div_done) begin
          cmd_o.tgt_apply = 1'b1;
          state_d         = ST_STRETCH;
        end
      end
      ST_STRETCH: begin
        if (status_i.settled) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.stretch = 1'b1;
          state_d       = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.div_start = 1'b1;
        if (status_i.cross_take) begin
          cmd_o.div_op = DIV_CROSS;
          state_d      = ST_XWAIT;
        end else begin
          state_d = ST_DWAIT;
        end
      end
      ST_XWAIT: begin
        cmd_o.div_op = DIV_CROSS;
        if (status_i.div_done) begin
          cmd_o.cross_apply = 1'b1;
          state_d           = ST_STRETCH;
        end
      end
      ST_DWAIT: begin
        if (status_i.div_done) begin
          cmd_o.step_apply = 1'b1;
          state_d          = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/throttle_ramp_limiter_failsafe.sv =====
// top level of the throttle ramp limiter with failsafe and safe-start arming
//
// input channel: in_valid_i/in_ready_o moves one word holding the throttle
//   command, the elapsed time in microseconds and the link-lost and setup flags
// output channel: out_valid_o/out_ready_i moves one word per input word with
//   the new ramped level, the target it aimed at and the arm flag
// config: apb-style port, deadzone at 0x0, accel rate at 0x4, decel rate at
//   0x8, coast rate at 0xc; pready is always high, write only while idle
// divider: each division runs on the shared divider (two quotient bits a cycle)
//   and holds the controller until it is done, up to three times per update
//   when the target needs rescaling and the level crosses zero
// flow: one word at a time; a new word is taken once the previous result sits
//   in the output register
// reset: level is zero, the block is unarmed, registers take their defaults
// stall: a held result stays in the output register; the next update runs and
//   waits in its last step until the output register frees up
`default_nettype none
`include "throttle_ramp_limiter_failsafe_macros.svh"
module throttle_ramp_limiter_failsafe #(
  parameter int unsigned FULL_SCALE = trl_pkg::FULL_SCALE_DEF,
  parameter int unsigned TIME_WIDTH = trl_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // apb config port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [trl_pkg::ADDR_W-1:0]          paddr,
  input  logic [trl_pkg::DATA_W-1:0]          pwdata,
  output logic [trl_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [trl_pkg::CMD_W-1:0]    command_level_i,
  input  logic [trl_pkg::ELAPSED_W-1:0]       elapsed_us_i,
  input  logic                                link_lost_i,
  input  logic                                setup_mode_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [trl_pkg::LEVEL_W-1:0]  ramped_level_o,
  output logic signed [trl_pkg::LEVEL_W-1:0]  target_level_o,
  output logic                                armed_o
);
  import trl_pkg::*;

  // largest level magnitude, used by the checks below
  localparam int unsigned LevelMax = (FULL_SCALE < 16383) ? FULL_SCALE : 16383;
  localparam logic signed [LEVEL_W-1:0] LvlPos = LEVEL_W'(LevelMax);
  localparam logic signed [LEVEL_W-1:0] LvlNeg = -LvlPos;

  trl_cfg_t    cfg;
  trl_cmd_t    cmd;
  trl_status_t status;

  // register file
  trl_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // sequencing: accept, target, one or two stretches, output
  trl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic, kept level and arm flag, output register
  trl_dp #(
    .FULL_SCALE(FULL_SCALE),
    .TIME_WIDTH(TIME_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .command_level_i(command_level_i),
    .elapsed_us_i   (elapsed_us_i),
    .link_lost_i    (link_lost_i),
    .setup_mode_i   (setup_mode_i),
    .status_o       (status),
    .ramped_level_o (ramped_level_o),
    .target_level_o (target_level_o),
    .armed_o        (armed_o)
  );

  // a lost link always disarms
  `TRL_ASSERT_NXT(a_lost_disarms, clk_i, rst_ni,
                  in_valid_i && in_ready_o && link_lost_i, !status.arm)
  // an unarmed result never aims anywhere but zero
  `TRL_ASSERT_IMP(a_unarmed_zero, clk_i, rst_ni, out_valid_o && !armed_o, target_level_o == '0)
  // the ramped level stays within full scale
  `TRL_ASSERT_IMP(a_level_range, clk_i, rst_ni, out_valid_o,
                  (ramped_level_o <= LvlPos) && (ramped_level_o >= LvlNeg))

endmodule
`default_nettype wire

// ===== tb/sv/tb_throttle_ramp_limiter_failsafe.sv =====
// testbench for the throttle ramp limiter: directed table, random phases, self-checking
`default_nettype none
module tb_throttle_ramp_limiter_failsafe;
  import trl_pkg::*;

  // bench timing and run length
  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 9;
  localparam int WORDS_PER_PHASE = 130;
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_AFTER = 40;
  localparam int TAIL_CYCLES = 100;
  localparam int MAX_PRINTED = 60;

  // fixed-point constants of the ramp arithmetic
  localparam longint USEC = US_PER_S;
  localparam longint FULL = FULL_SCALE_DEF;
  localparam longint LVL_CAP = (FULL < 16383) ? FULL : 16383;
  localparam int MAX_STRETCH = 10;
  localparam longint ELAPSED_MAX = (1 << ELAPSED_W) - 1;

  typedef struct packed {
    logic signed [CMD_W-1:0] cmd;
    logic [ELAPSED_W-1:0]    us;
    logic                    lost;
    logic                    setup;
  } throttle_word_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] lvl;
    logic signed [LEVEL_W-1:0] tgt;
    logic                      arm;
  } ramp_word_t;

  typedef struct packed {
    throttle_word_t stim;
    logic           typed;
    ramp_word_t     want;
  } step_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [CMD_W-1:0]    command_level_i = '0;
  logic [ELAPSED_W-1:0]       elapsed_us_i = '0;
  logic                       link_lost_i = 1'b0;
  logic                       setup_mode_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [LEVEL_W-1:0]  ramped_level_o;
  logic signed [LEVEL_W-1:0]  target_level_o;
  logic                       armed_o;

  // receiver readiness: the per-word draw, gated by the long hold-off
  logic rx_want = 1'b0;
  logic rx_hold = 1'b0;
  assign out_ready_i = rx_want && !rx_hold;

  // predictor state and its copy of the registers
  longint lvl_q = 0;
  bit     arm_q = 1'b0;
  longint dz_set = DEADZONE_RST;
  longint acc_set = ACCEL_RST;
  longint dec_set = DECEL_RST;
  longint cst_set = COAST_RST;

  ramp_word_t pending_ramps [$];
  int tx_count = 0;
  int rx_count = 0;
  int mismatches = 0;
  int cycle_count = 0;

  throttle_ramp_limiter_failsafe u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_level_i (command_level_i),
    .elapsed_us_i    (elapsed_us_i),
    .link_lost_i     (link_lost_i),
    .setup_mode_i    (setup_mode_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .ramped_level_o  (ramped_level_o),
    .target_level_o  (target_level_o),
    .armed_o         (armed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one line per mismatch, printing capped so a broken build stays readable
  task automatic note_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // ramp update: arming, deadzone rescale, then up to ten stretches of
  // movement with a stop at zero when the level would cross it
  function automatic ramp_word_t advance_ramp(input throttle_word_t w);
    longint cmd, mag, lvl, tgt, tleft, rate, prod, zdist, span;
    bit fs, acc;
    int n;
    ramp_word_t r;
    cmd = longint'($signed(w.cmd));
    tleft = longint'(w.us);
    mag = (cmd < 0) ? -cmd : cmd;
    lvl = lvl_q;
    tgt = 0;
    n = 0;
    // link loss disarms, a centered stick with link present arms
    if (w.lost) arm_q = 1'b0;
    if (!w.lost && mag <= dz_set) arm_q = 1'b1;
    fs = w.lost || w.setup || !arm_q;
    if (!fs && mag > dz_set) begin
      if (dz_set >= FULL) begin
        span = LVL_CAP;
      end else begin
        span = (mag - dz_set) * FULL / (FULL - dz_set);
        if (span > LVL_CAP) span = LVL_CAP;
      end
      tgt = (cmd < 0) ? -span : span;
    end
    while (tleft > 0 && lvl != tgt && n < MAX_STRETCH) begin
      n++;
      if (fs) begin
        rate = cst_set;
      end else begin
        // accelerating only when moving away from zero on the target's side
        acc = (tgt > 0 && tgt > lvl && lvl >= 0) || (tgt < 0 && tgt < lvl && lvl <= 0);
        rate = acc ? acc_set : dec_set;
      end
      prod = rate * tleft;
      zdist = (lvl < 0) ? -lvl : lvl;
      // strictly past zero: park at zero, spend the rest of the time at the new rate
      if (((lvl < tgt && lvl < 0 && tgt >= 0) || (lvl > tgt && lvl > 0 && tgt <= 0)) &&
          prod > zdist * USEC) begin
        lvl = 0;
        tleft -= (zdist * USEC + rate - 1) / rate;
        continue;
      end
      if (lvl < tgt) begin
        lvl += prod / USEC;
        if (lvl > tgt) lvl = tgt;
      end else begin
        lvl -= prod / USEC;
        if (lvl < tgt) lvl = tgt;
      end
      break;
    end
    lvl_q = lvl;
    r.lvl = LEVEL_W'(lvl);
    r.tgt = LEVEL_W'(tgt);
    r.arm = arm_q;
    return r;
  endfunction

  function automatic step_row_t mk_row(input int c, input int us, input bit l, input bit s,
                                       input bit t = 1'b0, input int wl = 0, input int wt = 0,
                                       input bit wa = 1'b0);
    step_row_t r;
    r.stim.cmd = CMD_W'(c);
    r.stim.us = ELAPSED_W'(us);
    r.stim.lost = l;
    r.stim.setup = s;
    r.typed = t;
    r.want.lvl = LEVEL_W'(wl);
    r.want.tgt = LEVEL_W'(wt);
    r.want.arm = wa;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] draw_rate();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 100000);
      1: return $urandom_range(0, (1 << RATE_W) - 1);
      2: return $urandom_range(0, 1) ? 0 : (1 << RATE_W) - 1;
      default: return $urandom_range(1000, 60000);
    endcase
  endfunction

  // random word: mostly link present with live commands, some failsafe noise,
  // and now and then a time chosen to land right at the zero crossing
  function automatic throttle_word_t draw_word();
    throttle_word_t w;
    longint mag, rate, t0;
    int pick;
    bit force_arm;
    w.lost = ($urandom_range(0, 99) < 6);
    w.setup = ($urandom_range(0, 99) < 6);
    w.cmd = CMD_W'($urandom_range(0, 20000) - 10000);
    pick = $urandom_range(0, 99);
    // an unarmed block needs a centered stick before anything moves
    force_arm = !arm_q && ($urandom_range(0, 2) == 0);
    if (force_arm) pick = 80;
    if (pick >= 60 && pick < 75) begin
      w.cmd = CMD_W'($urandom);
    end else if (pick >= 75 && pick < 88) begin
      mag = $urandom_range(0, dz_set);
      w.cmd = CMD_W'($urandom_range(0, 1) ? -mag : mag);
      if (force_arm) w.lost = 1'b0;
    end else if (pick >= 88) begin
      case ($urandom_range(0, 6))
        0: mag = -16384;
        1: mag = 16383;
        2: mag = -10000;
        3: mag = 10000;
        4: mag = 0;
        5: mag = dz_set;
        default: mag = dz_set + 1;
      endcase
      if ($urandom_range(0, 1)) mag = -mag;
      w.cmd = CMD_W'(mag);
    end
    pick = $urandom_range(0, 99);
    if (pick < 35) w.us = ELAPSED_W'($urandom_range(0, 20000));
    else if (pick < 65) w.us = ELAPSED_W'($urandom_range(0, 200000));
    else if (pick < 90) w.us = ELAPSED_W'($urandom);
    else case ($urandom_range(0, 2))
      0: w.us = '0;
      1: w.us = ELAPSED_W'(1);
      default: w.us = '1;
    endcase
    // zero-crossing probe: time for exactly the distance to zero, or one off
    if (lvl_q != 0 && $urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1)) begin
        w.lost = 1'b1;
        rate = cst_set;
      end else begin
        w.lost = 1'b0;
        w.setup = 1'b0;
        w.cmd = CMD_W'((lvl_q > 0) ? -10000 : 10000);
        rate = dec_set;
      end
      if (rate != 0) begin
        mag = (lvl_q < 0) ? -lvl_q : lvl_q;
        t0 = mag * USEC / rate + longint'($urandom_range(0, 2)) - 1;
        if (t0 < 0) t0 = 0;
        if (t0 > ELAPSED_MAX) t0 = ELAPSED_MAX;
        w.us = ELAPSED_W'(t0);
      end
    end
    return w;
  endfunction

  // apb write, then read back; the predictor picks up the new value
  task automatic cfg_write(input reg_idx_e idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] kept;
    kept = (idx == REG_DEADZONE) ? DATA_W'(val[DZ_W-1:0]) : DATA_W'(val[RATE_W-1:0]);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i) penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i) begin
      penable <= 1'b0;
      pwrite <= 1'b0;
    end
    @(negedge clk_i) penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== kept)
      note_mismatch($sformatf("register %s reads %0h, wrote %0h", idx.name(), prdata, kept));
    @(negedge clk_i) begin
      psel <= 1'b0;
      penable <= 1'b0;
    end
    case (idx)
      REG_DEADZONE: dz_set = longint'(kept);
      REG_ACCEL:    acc_set = longint'(kept);
      REG_DECEL:    dec_set = longint'(kept);
      REG_COAST:    cst_set = longint'(kept);
      default: ;
    endcase
  endtask

  // register settings per phase: extremes first, then random ones
  task automatic load_phase(input int ph);
    logic [DATA_W-1:0] d, a, b, c;
    case (ph)
      1: begin
        d = 0;
        a = (1 << RATE_W) - 1;
        b = (1 << RATE_W) - 1;
        c = (1 << RATE_W) - 1;
      end
      2: begin
        d = (1 << DZ_W) - 1;
        a = 1;
        b = 1;
        c = 1;
      end
      // zero rates freeze the level
      3: begin
        d = 5000;
        a = 0;
        b = 0;
        c = 0;
      end
      4: begin
        d = FULL - 1;
        a = 1000000;
        b = 1;
        c = 250;
      end
      // deadzone equal to full scale: anything outside it saturates
      5: begin
        d = FULL;
        a = draw_rate();
        b = draw_rate();
        c = draw_rate();
      end
      default: begin
        d = $urandom_range(0, 1) ? $urandom_range(0, 5000) : $urandom_range(0, (1 << DZ_W) - 1);
        a = draw_rate();
        b = draw_rate();
        c = draw_rate();
      end
    endcase
    cfg_write(REG_DEADZONE, d);
    cfg_write(REG_ACCEL, a);
    cfg_write(REG_DECEL, b);
    cfg_write(REG_COAST, c);
  endtask

  // offer one word after a random gap; entered and left at a falling edge
  task automatic send_word(input throttle_word_t w, input bit typed, input ramp_word_t typed_want);
    int gap;
    ramp_word_t pred;
    // every fourth stretch of 64 words runs back to back
    gap = (((tx_count / 64) % 4) == 3) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_level_i <= w.cmd;
    elapsed_us_i <= w.us;
    link_lost_i <= w.lost;
    setup_mode_i <= w.setup;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // the predictor always advances; a typed row overrides only the expectation
    pred = advance_ramp(w);
    pending_ramps.push_back(typed ? typed_want : pred);
    tx_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_ramps.size() != 0) @(negedge clk_i);
  endtask

  // result side: random stalls, every word checked against the oldest expectation
  initial begin : result_sink
    ramp_word_t got, want;
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = (((rx_count / 64) % 4) == 3) ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        rx_want <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rx_want <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
      got.lvl = ramped_level_o;
      got.tgt = target_level_o;
      got.arm = armed_o;
      if (pending_ramps.size() == 0) begin
        note_mismatch($sformatf("word with nothing expected: level %0d target %0d armed %0b",
                                $signed(got.lvl), $signed(got.tgt), got.arm));
      end else begin
        want = pending_ramps.pop_front();
        if (got.lvl !== want.lvl)
          note_mismatch($sformatf("word %0d ramped level %0d, expected %0d", rx_count,
                                  $signed(got.lvl), $signed(want.lvl)));
        if (got.tgt !== want.tgt)
          note_mismatch($sformatf("word %0d target level %0d, expected %0d", rx_count,
                                  $signed(got.tgt), $signed(want.tgt)));
        if (got.arm !== want.arm)
          note_mismatch($sformatf("word %0d armed %0b, expected %0b", rx_count,
                                  got.arm, want.arm));
      end
      rx_count++;
      @(negedge clk_i);
    end
  end

  // backpressure burst: the sink holds off while words keep coming, so the
  // output register fills and the input side has to stall
  initial begin : sink_hold
    wait (tx_count >= HOLD_AFTER);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin : stimulus
    step_row_t rows [$];
    // directed table, reset register values: deadzone 1000, accel 7500,
    // decel 50000, coast 20000; typed rows are readable straight off the rules
    rows = '{
      // unarmed after reset: no target, no movement
      mk_row(5000, 1000, 1'b0, 1'b0, 1'b1, 0, 0, 1'b0),
      // centered stick arms
      mk_row(0, 0, 1'b0, 1'b0, 1'b1, 0, 0, 1'b1),
      // full command, one second at the accelerate rate
      mk_row(10000, 1000000, 1'b0, 1'b0, 1'b1, 7500, 10000, 1'b1),
      // longest time clips at the target
      mk_row(10000, 'hFFFFF, 1'b0, 1'b0, 1'b1, 10000, 10000, 1'b1),
      // reversal with time for exactly the distance to zero: no crossing
      mk_row(-10000, 200000, 1'b0, 1'b0),
      mk_row(-10000, 'hFFFFF, 1'b0, 1'b0),
      // most negative command saturates the target
      mk_row(-16384, 0, 1'b0, 1'b0),
      // largest positive command, crossing zero then accelerating
      mk_row(16383, 500000, 1'b0, 1'b0),
      // link loss disarms and coasts down
      mk_row(10000, 100000, 1'b1, 1'b0),
      // link back but stick off center: still unarmed
      mk_row(10000, 100000, 1'b0, 1'b0),
      // stick at the deadzone edge arms
      mk_row(1000, 1, 1'b0, 1'b0),
      mk_row(1001, 200000, 1'b0, 1'b0),
      // settings mode forces a zero target
      mk_row(8000, 300000, 1'b0, 1'b1),
      mk_row(-1000, 0, 1'b0, 1'b0),
      mk_row(-1001, 1000000, 1'b0, 1'b0),
      mk_row(-9999, 'hFFFFF, 1'b0, 1'b0),
      // both flags at once
      mk_row(0, 'hFFFFF, 1'b1, 1'b1),
      mk_row(0, 0, 1'b0, 1'b0),
      mk_row(9999, 'hFFFFF, 1'b0, 1'b1),
      mk_row(-16384, 1, 1'b0, 1'b0)
    };
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (rows[i]) send_word(rows[i].stim, rows[i].typed, rows[i].want);
    for (int ph = 0; ph < PHASES; ph++) begin
      // registers change only with nothing in flight
      if (ph > 0) begin
        in_valid_i <= 1'b0;
        wait_drained();
        load_phase(ph);
      end
      repeat (WORDS_PER_PHASE) send_word(draw_word(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
